/* sv/pidc_pkg.sv */
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register indexes, reset values and pipeline words of the
// clamped PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUM_FLOOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUM_CEILING = 3'd6;

  localparam logic signed [15:0] DRIVE_FLOOR_RST   = 16'sh8000;
  localparam logic signed [15:0] DRIVE_CEILING_RST = 16'sh7fff;
  localparam logic signed [31:0] ACCUM_FLOOR_RST   = 32'sh8000_0000;
  localparam logic signed [31:0] ACCUM_CEILING_RST = 32'sh7fff_ffff;

  // error, integral and derivative of one sample
  typedef struct packed {
    logic               clr;
    logic signed [16:0] err;
    logic signed [31:0] acc;
    logic signed [17:0] deriv;
  } sample_t;

  // the three gain products of one sample
  typedef struct packed {
    logic               clr;
    logic signed [32:0] p_prod;
    logic signed [47:0] i_prod;
    logic signed [33:0] d_prod;
  } prod_t;

endpackage

`default_nettype wire

/* sv/pidc_if.sv */
// ----------------------------------------------------------------------------
// pidc_if
// Valid/ready channels of the clamped PID controller: sample in, drive out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] setpoint;
  logic signed [15:0] measured;
  logic               clear_history;

  modport source (output valid, output setpoint, output measured,
                  output clear_history, input ready);
  modport sink   (input valid, input setpoint, input measured,
                  input clear_history, output ready);
endinterface

interface pidc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

/* sv/pidc_integrator.sv */
// ----------------------------------------------------------------------------
// pidc_integrator
// Error, clamped integral and derivative of each accepted sample; holds the
// integral and previous error history.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_integrator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic signed [15:0] setpoint_i,
  input  wire logic signed [15:0] measured_i,
  input  wire logic               clear_i,
  input  wire logic signed [31:0] accum_floor_i,
  input  wire logic signed [31:0] accum_ceiling_i,
  output pidc_pkg::sample_t       sample_o
);

  logic signed [31:0] acc_q;
  logic signed [16:0] last_q;
  logic signed [16:0] err;
  logic signed [32:0] acc_sum;
  logic signed [31:0] acc_d;
  logic signed [17:0] deriv;
  pidc_pkg::sample_t  sample_q;

  assign err     = 17'(setpoint_i) - 17'(measured_i);
  assign acc_sum = 33'(acc_q) + 33'(err);
  assign deriv   = 18'(err) - 18'(last_q);

  // ceiling wins over floor
  always_comb begin
    priority if (acc_sum > 33'(accum_ceiling_i)) begin
      acc_d = accum_ceiling_i;
    end else if (acc_sum < 33'(accum_floor_i)) begin
      acc_d = accum_floor_i;
    end else begin
      acc_d = acc_sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      last_q <= '0;
    end else if (en_i) begin
      if (clear_i) begin
        acc_q  <= '0;
        last_q <= '0;
      end else begin
        acc_q  <= acc_d;
        last_q <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q.clr   <= clear_i;
      sample_q.err   <= err;
      sample_q.acc   <= acc_d;
      sample_q.deriv <= deriv;
    end
  end

  assign sample_o = sample_q;

endmodule

`default_nettype wire

/* sv/pid_controller_clamped_core.sv */
// ----------------------------------------------------------------------------
// pid_controller_clamped_core
// Positional PID controller in fixed point with integral and drive clamps.
// ----------------------------------------------------------------------------
// Takes one sample word per clock while the output is not stalled, and returns
// one drive word per sample, in order. After a sample is accepted, registers
// hold in turn the error and the integral update, the three gain multiplies,
// and the sum, the shift by 8 and the drive clamp. The rate of one word per
// cycle is set by the integral add-and-clamp, closed on its own register.
// The user writes gains and limits through the configuration port only while
// no sample is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pidc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pidc_in_if.sink                              sample_i,
  pidc_out_if.source                           result_o
);

  logic signed [15:0] gain_p_q;
  logic signed [15:0] gain_i_q;
  logic signed [15:0] gain_d_q;
  logic signed [15:0] drive_floor_q;
  logic signed [15:0] drive_ceiling_q;
  logic signed [31:0] accum_floor_q;
  logic signed [31:0] accum_ceiling_q;

  logic               s1_valid_q;
  logic               s2_valid_q;
  logic               out_valid_q;
  logic               s1_en;
  logic               s2_en;
  logic               s3_en;

  pidc_pkg::sample_t  sample;
  pidc_pkg::prod_t    prod_d;
  pidc_pkg::prod_t    prod_q;
  logic signed [49:0] sum;
  logic signed [41:0] shifted;
  logic signed [15:0] drive_d;
  logic signed [15:0] drive_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q        <= '0;
      gain_i_q        <= '0;
      gain_d_q        <= '0;
      drive_floor_q   <= pidc_pkg::DRIVE_FLOOR_RST;
      drive_ceiling_q <= pidc_pkg::DRIVE_CEILING_RST;
      accum_floor_q   <= pidc_pkg::ACCUM_FLOOR_RST;
      accum_ceiling_q <= pidc_pkg::ACCUM_CEILING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pidc_pkg::REG_GAIN_P:        gain_p_q        <= cfg_data_i[15:0];
        pidc_pkg::REG_GAIN_I:        gain_i_q        <= cfg_data_i[15:0];
        pidc_pkg::REG_GAIN_D:        gain_d_q        <= cfg_data_i[15:0];
        pidc_pkg::REG_DRIVE_FLOOR:   drive_floor_q   <= cfg_data_i[15:0];
        pidc_pkg::REG_DRIVE_CEILING: drive_ceiling_q <= cfg_data_i[15:0];
        pidc_pkg::REG_ACCUM_FLOOR:   accum_floor_q   <= cfg_data_i[31:0];
        pidc_pkg::REG_ACCUM_CEILING: accum_ceiling_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign s3_en          = s2_valid_q && (!out_valid_q || result_o.ready);
  assign s2_en          = s1_valid_q && (!s2_valid_q || s3_en);
  assign sample_i.ready = !s1_valid_q || s2_en;
  assign s1_en          = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en || s2_en) begin
        s1_valid_q <= s1_en;
      end
      if (s2_en || s3_en) begin
        s2_valid_q <= s2_en;
      end
      if (s3_en || result_o.ready) begin
        out_valid_q <= s3_en;
      end
    end
  end

  pidc_integrator u_integrator (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (s1_en),
    .setpoint_i      (sample_i.setpoint),
    .measured_i      (sample_i.measured),
    .clear_i         (sample_i.clear_history),
    .accum_floor_i   (accum_floor_q),
    .accum_ceiling_i (accum_ceiling_q),
    .sample_o        (sample)
  );

  // gain products
  always_comb begin
    prod_d.clr    = sample.clr;
    prod_d.p_prod = 33'(gain_p_q) * 33'(sample.err);
    prod_d.i_prod = 48'(gain_i_q) * 48'(sample.acc);
    prod_d.d_prod = 34'(gain_d_q) * 34'(sample.deriv);
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      prod_q <= prod_d;
    end
  end

  // sum, floor shift and drive clamp, or zero drive on a cleared sample
  assign sum     = 50'(prod_q.p_prod) + 50'(prod_q.i_prod) + 50'(prod_q.d_prod);
  assign shifted = 42'(sum >>> 8);

  always_comb begin
    priority if (prod_q.clr) begin
      drive_d = '0;
    end else if (shifted > 42'(drive_ceiling_q)) begin
      drive_d = drive_ceiling_q;
    end else if (shifted < 42'(drive_floor_q)) begin
      drive_d = drive_floor_q;
    end else begin
      drive_d = shifted[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      drive_q <= drive_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.drive = drive_q;

endmodule

`default_nettype wire
